// ----- hw/rtl/pac_pkg.sv -----
`timescale 1ns / 1ps

package pac_pkg;

  localparam int WORD_W   = 32;
  localparam int FRAC_W   = 16;
  localparam int SQ_STEPS = 25;
  localparam int DIV_BITS = 32;

  // pipeline stage positions
  localparam int ST_IN   = 0;
  localparam int ST_MUL  = ST_IN + SQ_STEPS + 1;
  localparam int ST_SAT  = ST_MUL + 1;
  localparam int ST_DIV0 = ST_SAT + 1;
  localparam int ST_OUT  = ST_DIV0 + DIV_BITS;
  localparam int NSTAGE  = ST_OUT + 1;

  typedef enum logic [1:0] {
    KIND_POINT   = 2'd0,
    KIND_HERN    = 2'd1,
    KIND_PLUM    = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT_FLAG = 2'd1,
    ST_ZERO_DEN = 2'd2,
    ST_BAD_TYPE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_TYPE  = 2'd0,
    REG_MASS  = 2'd1,
    REG_SOFT  = 2'd2,
    REG_SPARE = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [27:0] rem;
    logic [24:0] root;
  } sq_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] gm;
    logic        xneg;
    logic [31:0] xmag;
    logic [31:0] r2;
    logic [32:0] v;
    logic [31:0] a2;
    sq_t         sq_v;
    sq_t         sq_a;
    logic [43:0] den;
    logic [63:0] num;
    logic        sat;
    logic [63:0] rem_d;
    logic [31:0] quo;
    logic [31:0] acc;
    status_t     stat;
  } pipe_t;

  // one digit of the shift-subtract square root, two radicand bits per step
  function automatic sq_t sqrt_step(sq_t cur, logic [1:0] pair);
    logic [27:0] acc;
    logic [27:0] trial;
    sq_t         res;
    acc   = {cur.rem[25:0], pair};
    trial = {1'b0, cur.root, 2'b01};
    if (acc >= trial) begin
      res.rem  = acc - trial;
      res.root = {cur.root[23:0], 1'b1};
    end else begin
      res.rem  = acc;
      res.root = {cur.root[23:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ----- hw/rtl/potential_acceleration_component.sv -----
`timescale 1ns / 1ps

// channel  | signals                        | payload
// s_axis   | tvalid tready tdata[63:0]      | coord_offset, dist_sq
// m_axis   | tvalid tready tdata[31:0] tuser| accel / status
// cfg      | valid ready index[1:0] data    | register write
//
// one transaction accepted per cycle unless m_axis stalls; the stages are the input
// register, 25 square-root digit stages, multiply, saturation check, 32 quotient-bit
// stages and the output register.
// rst clears all stage valid bits and the registers to their reset values.
// a stall at m_axis freezes the whole pipe; s_axis_tready falls with it.
module potential_acceleration_component import pac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // coord_offset[31:0], dist_sq[63:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // accel[31:0]
  output logic [1:0]  m_axis_tuser,  // status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  kind_t       potential_type;
  logic [31:0] grav_mass;
  logic [31:0] softening_sq;

  logic        vld [NSTAGE];
  pipe_t       st [NSTAGE];
  pipe_t       st_next [NSTAGE];
  logic        en;

  assign cfg_ready     = 1'b1;
  assign en            = !vld[ST_OUT] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld[ST_OUT];
  assign m_axis_tdata  = st[ST_OUT].acc;
  assign m_axis_tuser  = st[ST_OUT].stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      potential_type <= KIND_POINT;
      grav_mass      <= 32'h0001_0000;
      softening_sq   <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_TYPE: potential_type <= kind_t'(cfg_data[1:0]);
        REG_MASS: grav_mass      <= cfg_data;
        REG_SOFT: softening_sq   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input stage
  always_comb begin
    logic [31:0] x;
    x = s_axis_tdata[31:0];
    st_next[ST_IN]       = '0;
    st_next[ST_IN].kind  = potential_type;
    st_next[ST_IN].gm    = grav_mass;
    st_next[ST_IN].xneg  = x[31];
    st_next[ST_IN].xmag  = x[31] ? (~x + 32'd1) : x;
    st_next[ST_IN].r2    = s_axis_tdata[63:32];
    st_next[ST_IN].a2    = softening_sq;
    st_next[ST_IN].v     = (potential_type == KIND_PLUM) ?
                           ({1'b0, s_axis_tdata[63:32]} + {1'b0, softening_sq}) :
                           {1'b0, s_axis_tdata[63:32]};
  end

  // square roots of v and of a2, both in Q16.16
  for (genvar j = 1; j <= SQ_STEPS; j++) begin : g_sqrt
    localparam int I = SQ_STEPS - j;
    logic [49:0] src_v;
    logic [49:0] src_a;
    assign src_v = {st[j-1].v, 17'd0} >> 1;
    assign src_a = {2'b00, st[j-1].a2, 16'd0};
    always_comb begin
      st_next[j]      = st[j-1];
      st_next[j].sq_v = sqrt_step(st[j-1].sq_v, src_v[2*I+1 -: 2]);
      st_next[j].sq_a = sqrt_step(st[j-1].sq_a, src_a[2*I+1 -: 2]);
    end
  end

  // denominator and numerator products
  always_comb begin
    pipe_t       p;
    logic [25:0] s;
    logic [33:0] opa;
    logic [25:0] opb;
    logic [59:0] prod;
    p    = st[ST_MUL-1];
    s    = {1'b0, p.sq_v.root} + {1'b0, p.sq_a.root};
    case (p.kind)
      KIND_POINT: begin
        opa = {2'b00, p.r2};
        opb = {1'b0, p.sq_v.root};
      end
      KIND_HERN: begin
        opa = {8'd0, s};
        opb = s;
      end
      KIND_PLUM: begin
        opa = {1'b0, p.v};
        opb = {1'b0, p.sq_v.root};
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
    prod           = opa * opb;
    st_next[ST_MUL]     = p;
    st_next[ST_MUL].den = prod[59:FRAC_W];
    st_next[ST_MUL].num = p.gm * p.xmag;
  end

  // quotient exceeds its limit exactly when num >= (limit + 1) * den
  always_comb begin
    pipe_t       p;
    logic [75:0] lim;
    p   = st[ST_SAT-1];
    lim = {1'b0, p.den, 31'd0};
    if (!p.xneg) begin
      lim = lim + {32'd0, p.den};
    end
    st_next[ST_SAT]       = p;
    st_next[ST_SAT].sat   = ({12'd0, p.num} >= lim);
    st_next[ST_SAT].rem_d = p.num;
    st_next[ST_SAT].quo   = '0;
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
    localparam int B = DIV_BITS - 1 - k;
    logic [75:0] trial;
    assign trial = {32'd0, st[ST_DIV0+k-1].den} << B;
    always_comb begin
      st_next[ST_DIV0+k] = st[ST_DIV0+k-1];
      if ({12'd0, st[ST_DIV0+k-1].rem_d} >= trial) begin
        st_next[ST_DIV0+k].rem_d  = st[ST_DIV0+k-1].rem_d - trial[63:0];
        st_next[ST_DIV0+k].quo[B] = 1'b1;
      end
    end
  end

  // result formatting
  always_comb begin
    pipe_t p;
    p = st[ST_OUT-1];
    st_next[ST_OUT] = p;
    if (p.kind == KIND_INVALID) begin
      st_next[ST_OUT].acc  = '0;
      st_next[ST_OUT].stat = ST_BAD_TYPE;
    end else if (p.den == '0) begin
      st_next[ST_OUT].acc  = '0;
      st_next[ST_OUT].stat = ST_ZERO_DEN;
    end else if (p.sat) begin
      st_next[ST_OUT].acc  = p.xneg ? 32'h7fff_ffff : 32'h8000_0000;
      st_next[ST_OUT].stat = ST_SAT_FLAG;
    end else begin
      st_next[ST_OUT].acc  = p.xneg ? p.quo : (~p.quo + 32'd1);
      st_next[ST_OUT].stat = ST_OK;
    end
  end

  for (genvar i = 0; i < NSTAGE; i++) begin : g_reg
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= (i == 0) ? s_axis_tvalid : vld[(i == 0) ? 0 : i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[i] <= st_next[i];
      end
    end
  end

  a_bad_type_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == ST_BAD_TYPE || m_axis_tuser == ST_ZERO_DEN)
      |-> m_axis_tdata == 32'd0)
    else $error("special status with nonzero accel");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == ST_SAT_FLAG
      |-> (m_axis_tdata == 32'h7fff_ffff || m_axis_tdata == 32'h8000_0000))
    else $error("saturated result not at a limit");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule
